// ===== hw/rtl/lfps_pkg.sv =====
`timescale 1ns / 1ps
// Package for the line-following steering controller: sizes, constants, codes,
// shared structs and the motor drive function. No dependencies.
package lfps_pkg;

    localparam int NUM_SENSORS   = 8;
    localparam int SAMPLE_BITS   = 10;
    localparam int IDX_W         = $clog2(NUM_SENSORS);

    localparam int NORM_FULL     = 1000;
    localparam int NORM_W        = 10;
    localparam int MIN_RANGE     = 100;
    localparam int COUNT_FLOOR   = 200;
    localparam int SEEN_LEVEL    = 800;
    localparam int LOST_LIMIT    = 600;
    localparam int LOST_W        = 10;
    localparam int LOST_MAX      = 1023;
    localparam int DEADBAND      = 1280;
    localparam int LOW_BAND      = 5120;
    localparam int HIGH_BAND     = 8960;
    localparam int GAP_BAND      = 3840;
    localparam int TURN_BAND     = 1280;
    localparam int ADJ_LIMIT     = 140;
    localparam int KICK_SPEED    = 20;
    localparam int INNER_REVERSE = 30;

    // Lane divider: (sample - low) * 1000 divided by the channel range.
    localparam int LDIV_W = SAMPLE_BITS + NORM_W;
    localparam int LCNT_W = $clog2(LDIV_W + 1);

    // Centroid sums and error divider.
    localparam int SV_W   = NORM_W + IDX_W;
    localparam int WGT_W  = 9;
    localparam int SW_W   = SV_W + WGT_W;
    localparam int EDIV_W = SW_W + 8;
    localparam int ECNT_W = $clog2(EDIV_W + 1);

    localparam int E_W    = 16;
    localparam int F_W    = 24;
    localparam int DRV_W  = 10;

    localparam int KP_W   = 12;
    localparam int KD_W   = 13;
    localparam int SPD_W  = 8;
    localparam int GAPT_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W  = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP, CFG_KD, CFG_BASE, CFG_MINC, CFG_MAX, CFG_GAP, CFG_REC, CFG_GAPT
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_CAL   = 2'd1,
        REQ_STEP  = 2'd2
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE, S_NORM, S_SUM, S_DECIDE, S_DIV, S_ERR, S_MUL1, S_MUL2, S_MUL3,
        S_ACC, S_LOST, S_KICK, S_RESULT
    } t_state;

    typedef struct packed {
        logic [KP_W-1:0]   kp_gain;
        logic [KD_W-1:0]   kd_gain;
        logic [SPD_W-1:0]  cruise_spd;
        logic [SPD_W-1:0]  min_curve_speed;
        logic [SPD_W-1:0]  top_spd;
        logic [SPD_W-1:0]  bridge_spd;
        logic [SPD_W-1:0]  return_spd;
        logic [GAPT_W-1:0] bridge_limit;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic cal;
        logic start;
    } t_lane_cmd;

    typedef struct packed {
        logic             fwd;
        logic [SPD_W-1:0] duty;
    } t_motor;

    typedef struct packed {
        logic             left_forward;
        logic [SPD_W-1:0] left_duty;
        logic             right_forward;
        logic [SPD_W-1:0] right_duty;
        logic             line_seen;
        logic             run_ended;
        logic             last_of_run;
    } t_result;

    // Centroid weight of a channel: 20*i - 10*(N-1).
    function automatic logic signed [WGT_W-1:0] weight(input logic [IDX_W-1:0] i);
        return WGT_W'(20 * int'(i) - 10 * (NUM_SENSORS - 1));
    endfunction

    // Direction and duty for a signed speed, magnitude clamped to the top speed.
    function automatic t_motor drive(input logic signed [DRV_W-1:0] v,
                                     input logic [SPD_W-1:0] max_s);
        logic [DRV_W-1:0] mag;
        logic [SPD_W-1:0] m;
        t_motor r;
        mag = v[DRV_W-1] ? DRV_W'(-v) : DRV_W'(v);
        m = (mag > DRV_W'(max_s)) ? max_s : mag[SPD_W-1:0];
        r.fwd = ~v[DRV_W-1];
        r.duty = r.fwd ? (SPD_W'(255) - m) : m;
        return r;
    endfunction

endpackage

// ===== hw/rtl/lfps_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces for the sensor item channel and the motor result channel.
// Depends on nothing; the payload mirrors the block's item and result fields.
interface lfps_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [9:0] sample_ch0;
    logic [9:0] sample_ch1;
    logic [9:0] sample_ch2;
    logic [9:0] sample_ch3;
    logic [9:0] sample_ch4;
    logic [9:0] sample_ch5;
    logic [9:0] sample_ch6;
    logic [9:0] sample_ch7;

    modport source (output valid, req_type, sample_ch0, sample_ch1, sample_ch2,
                    sample_ch3, sample_ch4, sample_ch5, sample_ch6, sample_ch7,
                    input ready);
    modport sink (input valid, req_type, sample_ch0, sample_ch1, sample_ch2,
                  sample_ch3, sample_ch4, sample_ch5, sample_ch6, sample_ch7,
                  output ready);
endinterface

interface lfps_result_if;
    logic       valid;
    logic       ready;
    logic       left_forward;
    logic [7:0] left_duty;
    logic       right_forward;
    logic [7:0] right_duty;
    logic       line_seen;
    logic       run_ended;
    logic       last_of_run;

    modport source (output valid, left_forward, left_duty, right_forward, right_duty,
                    line_seen, run_ended, last_of_run, input ready);
    modport sink (input valid, left_forward, left_duty, right_forward, right_duty,
                  line_seen, run_ended, last_of_run, output ready);
endinterface

// ===== hw/rtl/lfps_lane.sv =====
`timescale 1ns / 1ps
// One sensor lane: calibration limits and a bit-serial normaliser to 0..1000.
// Depends on lfps_pkg.
module lfps_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lfps_pkg::t_lane_cmd                 i_cmd,
    input  logic [lfps_pkg::SAMPLE_BITS-1:0]    i_sample,
    output logic [lfps_pkg::NORM_W-1:0]         o_norm,
    output logic                                o_busy
);
    import lfps_pkg::*;

    logic [SAMPLE_BITS-1:0] r_low, r_high, r_div, r_rem;
    logic [LDIV_W-1:0]      r_quo;
    logic [LCNT_W-1:0]      r_cnt;
    logic                   r_valid;

    logic signed [SAMPLE_BITS:0] range_s;
    logic [SAMPLE_BITS-1:0]      diff;
    logic [SAMPLE_BITS:0]        rem_sh;
    logic                        ge;
    logic [NORM_W-1:0]           qc;

    assign range_s = $signed({1'b0, r_high}) - $signed({1'b0, r_low});
    assign diff    = (i_sample > r_low) ? (i_sample - r_low) : '0;
    assign rem_sh  = {r_rem, r_quo[LDIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign qc      = (r_quo > LDIV_W'(NORM_FULL)) ? NORM_W'(NORM_FULL) : r_quo[NORM_W-1:0];
    assign o_norm  = (r_valid && qc > NORM_W'(COUNT_FLOOR)) ? qc : '0;
    assign o_busy  = r_cnt != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '1;
            r_high  <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_low  <= '1;
                r_high <= '0;
            end else if (i_cmd.cal) begin
                if (i_sample < r_low) r_low <= i_sample;
                if (i_sample > r_high) r_high <= i_sample;
            end
            if (i_cmd.start) begin
                r_valid <= range_s >= $signed((SAMPLE_BITS+1)'(MIN_RANGE));
                r_div   <= range_s[SAMPLE_BITS-1:0];
                r_rem   <= '0;
                r_quo   <= LDIV_W'(diff) * LDIV_W'(NORM_FULL);
                r_cnt   <= LCNT_W'(LDIV_W);
            end else if (o_busy) begin
                r_rem <= ge ? SAMPLE_BITS'(rem_sh - {1'b0, r_div}) : rem_sh[SAMPLE_BITS-1:0];
                r_quo <= {r_quo[LDIV_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/lfps_ctrl.sv =====
`timescale 1ns / 1ps
// Merging stage and control sequencer: centroid sums, error divider, filter,
// gain scheduling, line-loss recovery and the result register. Depends on lfps_pkg.
module lfps_ctrl (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  lfps_pkg::t_cfg                                i_cfg,
    input  logic                                          i_in_valid,
    input  logic [1:0]                                    i_req,
    output logic                                          o_in_ready,
    input  logic [lfps_pkg::NUM_SENSORS-1:0][lfps_pkg::NORM_W-1:0] i_norm,
    input  logic [lfps_pkg::NUM_SENSORS-1:0]              i_busy,
    output lfps_pkg::t_lane_cmd                           o_cmd,
    output logic                                          o_res_valid,
    input  logic                                          i_res_ready,
    output lfps_pkg::t_result                             o_res
);
    import lfps_pkg::*;

    localparam int P_W   = 38;
    localparam int P2_W  = 32;
    localparam int M1_W  = 29;
    localparam int M1S_W = 40;
    localparam int M2_W  = 38;
    localparam int ACC_W = 44;

    t_state r_state, n_state;

    logic [IDX_W-1:0]         r_idx;
    logic signed [SW_W-1:0]   r_sw;
    logic [SV_W-1:0]          r_sv;
    logic [EDIV_W-1:0]        r_equo;
    logic [SV_W-1:0]          r_erem;
    logic [ECNT_W-1:0]        r_ecnt;
    logic                     r_neg;
    logic [E_W-2:0]           r_ae;
    logic signed [E_W-1:0]    r_e, r_prev;
    logic signed [F_W-1:0]    r_f;
    logic signed [P_W-1:0]    r_p1;
    logic signed [P2_W-1:0]   r_p2;
    logic signed [M1_W-1:0]   r_m1;
    logic signed [M1S_W-1:0]  r_m1s;
    logic signed [M2_W-1:0]   r_m2;
    logic [8:0]               r_scale;
    logic [23:0]              r_dprod;
    logic [SPD_W-1:0]         r_sp;
    logic signed [DRV_W-1:0]  r_left, r_right;
    logic                     r_seen;
    logic [LOST_W-1:0]        r_lost;
    logic                     r_ended;
    logic                     r_out_valid;
    t_result                  r_out;

    logic accept, slot_free, load_kick, load_main;

    logic [NORM_W-1:0]        norm_sel;
    logic signed [SW_W-1:0]   prod;
    logic [SW_W-1:0]          sw_mag;
    logic [SV_W:0]            rem_sh;
    logic                     ge;
    logic signed [E_W-1:0]    q_s;
    logic signed [E_W:0]      de;
    logic signed [P_W-1:0]    fsum;
    logic [P_W-1:0]           fmag, fq;
    logic signed [DRV_W-1:0]  sp_raw;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]         amag, aq;
    logic signed [8:0]        adj;
    logic [LOST_W-1:0]        lost_new;
    logic signed [DRV_W-1:0]  gap_v, rec_v, inner_v;
    t_motor                   m_l, m_r, m_k;

    assign accept    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_res_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req == REQ_STEP) n_state = r_ended ? S_RESULT : S_NORM;
            end
            S_NORM:   if (i_busy == '0) n_state = S_SUM;
            S_SUM:    if (r_idx == IDX_W'(NUM_SENSORS - 1)) n_state = S_DECIDE;
            S_DECIDE: n_state = (r_sv > SV_W'(SEEN_LEVEL)) ? S_DIV : S_LOST;
            S_DIV:    if (r_ecnt == ECNT_W'(1)) n_state = S_ERR;
            S_ERR:    n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_MUL3;
            S_MUL3:   n_state = S_ACC;
            S_ACC:    n_state = S_RESULT;
            S_LOST:   n_state = (r_lost == '0) ? S_KICK : S_RESULT;
            S_KICK:   if (slot_free) n_state = S_RESULT;
            S_RESULT: if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready  = r_state == S_IDLE;
        load_kick   = (r_state == S_KICK) && slot_free;
        load_main   = (r_state == S_RESULT) && slot_free;
        o_cmd.clear = accept && i_req == REQ_CLEAR;
        o_cmd.cal   = accept && i_req == REQ_CAL;
        o_cmd.start = accept && i_req == REQ_STEP && !r_ended;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // Datapath arithmetic.
    always_comb begin
        norm_sel = i_norm[r_idx];
        prod     = SW_W'($signed({1'b0, norm_sel})) * SW_W'(weight(r_idx));
        sw_mag   = r_sw[SW_W-1] ? SW_W'(-r_sw) : SW_W'(r_sw);
        rem_sh   = {r_erem, r_equo[EDIV_W-1]};
        ge       = rem_sh >= {1'b0, r_sv};
        q_s      = $signed({1'b0, r_equo[E_W-2:0]});
        de       = (E_W+1)'(r_e) - (E_W+1)'(r_prev);
        fsum     = r_p1 + P_W'(r_p2);
        fmag     = fsum[P_W-1] ? P_W'(-fsum) : P_W'(fsum);
        fq       = (fmag + P_W'(2048)) >> 12;
        sp_raw   = $signed({2'b0, i_cfg.cruise_spd}) - $signed({2'b0, r_dprod[23:16]});
        acc      = ACC_W'(r_m1s) + (ACC_W'(r_m2) <<< 4);
        amag     = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        aq       = amag >> 24;
        adj      = (aq > ACC_W'(ADJ_LIMIT)) ? 9'(ADJ_LIMIT) : 9'(aq);
        if (acc[ACC_W-1]) adj = -adj;
        lost_new = (r_lost < LOST_W'(LOST_MAX)) ? r_lost + 1'b1 : r_lost;
        gap_v    = $signed({2'b0, i_cfg.bridge_spd});
        rec_v    = $signed({2'b0, i_cfg.return_spd});
        inner_v  = DRV_W'(-INNER_REVERSE);
        m_l      = drive(r_left, i_cfg.top_spd);
        m_r      = drive(r_right, i_cfg.top_spd);
        m_k      = drive(DRV_W'(-KICK_SPEED), i_cfg.top_spd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_f     <= '0;
            r_lost  <= '0;
            r_ended <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && i_req == REQ_CLEAR) begin
                        r_prev  <= '0;
                        r_f     <= '0;
                        r_lost  <= '0;
                        r_ended <= 1'b0;
                    end
                    // A step after the run has ended just reports the stop.
                    r_left  <= '0;
                    r_right <= '0;
                    r_seen  <= 1'b0;
                end
                S_NORM: begin
                    r_idx <= '0;
                    r_sw  <= '0;
                    r_sv  <= '0;
                end
                S_SUM: begin
                    r_sw  <= r_sw + prod;
                    r_sv  <= r_sv + SV_W'(norm_sel);
                    r_idx <= r_idx + 1'b1;
                end
                S_DECIDE: begin
                    r_neg  <= r_sw[SW_W-1];
                    r_equo <= EDIV_W'({sw_mag[SW_W-2:0], 8'b0}) + EDIV_W'(r_sv >> 1);
                    r_erem <= '0;
                    r_ecnt <= ECNT_W'(EDIV_W);
                end
                S_DIV: begin
                    r_erem <= ge ? SV_W'(rem_sh - {1'b0, r_sv}) : rem_sh[SV_W-1:0];
                    r_equo <= {r_equo[EDIV_W-2:0], ge};
                    r_ecnt <= r_ecnt - 1'b1;
                end
                S_ERR: begin
                    r_ae   <= r_equo[E_W-2:0];
                    r_e    <= (r_equo[E_W-2:0] < (E_W-1)'(DEADBAND)) ? '0 :
                              (r_neg ? -q_s : q_s);
                    r_lost <= '0;
                end
                S_MUL1: begin
                    r_p1 <= P_W'(r_f) * P_W'(13'sd3686);
                    r_p2 <= (P2_W'(de) <<< 4) * P2_W'(11'sd410);
                    r_m1 <= M1_W'(r_e) * M1_W'($signed({1'b0, i_cfg.kp_gain}));
                    if (r_ae < (E_W-1)'(LOW_BAND)) begin
                        r_scale <= 9'd77;
                        r_dprod <= 24'(r_ae) * 24'd307;
                    end else if (r_ae > (E_W-1)'(HIGH_BAND)) begin
                        r_scale <= 9'd461;
                        r_dprod <= 24'(r_ae) * 24'd461;
                    end else begin
                        r_scale <= 9'd256;
                        r_dprod <= 24'(r_ae) * 24'd307;
                    end
                end
                S_MUL2: begin
                    r_f    <= fsum[P_W-1] ? -F_W'(fq) : F_W'(fq);
                    r_m1s  <= M1S_W'(r_m1) * M1S_W'($signed({1'b0, r_scale}));
                    r_sp   <= (sp_raw < $signed({2'b0, i_cfg.min_curve_speed})) ?
                              i_cfg.min_curve_speed : sp_raw[SPD_W-1:0];
                    r_prev <= r_e;
                end
                S_MUL3: begin
                    r_m2 <= M2_W'(r_f) * M2_W'($signed({1'b0, i_cfg.kd_gain}));
                end
                S_ACC: begin
                    r_left  <= $signed({2'b0, r_sp}) - DRV_W'(adj);
                    r_right <= $signed({2'b0, r_sp}) + DRV_W'(adj);
                    r_seen  <= 1'b1;
                end
                S_LOST: begin
                    r_lost <= lost_new;
                    r_seen <= 1'b0;
                    if (lost_new > LOST_W'(LOST_LIMIT)) begin
                        r_ended <= 1'b1;
                        r_left  <= '0;
                        r_right <= '0;
                    end else if (lost_new < i_cfg.bridge_limit &&
                                 r_prev < $signed(E_W'(GAP_BAND)) &&
                                 r_prev > -$signed(E_W'(GAP_BAND))) begin
                        r_left  <= gap_v;
                        r_right <= gap_v;
                    end else if (r_prev < -$signed(E_W'(TURN_BAND))) begin
                        r_left  <= rec_v;
                        r_right <= inner_v;
                    end else if (r_prev > $signed(E_W'(TURN_BAND))) begin
                        r_left  <= inner_v;
                        r_right <= rec_v;
                    end else begin
                        r_left  <= gap_v;
                        r_right <= gap_v;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_kick) begin
            r_out_valid         <= 1'b1;
            r_out.left_forward  <= m_k.fwd;
            r_out.left_duty     <= m_k.duty;
            r_out.right_forward <= m_k.fwd;
            r_out.right_duty    <= m_k.duty;
            r_out.line_seen     <= 1'b0;
            r_out.run_ended     <= r_ended;
            r_out.last_of_run   <= 1'b0;
        end else if (load_main) begin
            r_out_valid         <= 1'b1;
            r_out.left_forward  <= m_l.fwd;
            r_out.left_duty     <= m_l.duty;
            r_out.right_forward <= m_r.fwd;
            r_out.right_duty    <= m_r.duty;
            r_out.line_seen     <= r_seen;
            r_out.run_ended     <= r_ended;
            r_out.last_of_run   <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== hw/rtl/line_follow_pid_steering_top.sv =====
`timescale 1ns / 1ps
// Top level of the line-following PID steering controller.
// Depends on lfps_pkg, lfps_if, lfps_lane and lfps_ctrl.
//
//  Channel    | Direction | Handshake         | Contents
//  -----------+-----------+-------------------+-----------------------------------
//  i_item     | in        | valid / ready     | request type and eight samples
//  o_result   | out       | valid / ready     | motor directions, duties, flags
//  i_cfg_*    | in        | write enable only | register index and data
//
// A control step that finds the line passes through idle, the lane normalisers
// (a bit-serial divider per lane, one quotient bit a cycle), the merging sum,
// the serial centroid divider, and filter, gains and the result load. A lost
// step skips the divider and filter, loading the reverse kick first on the
// first lost step; a step after the run has ended goes straight to the result load.
// Clear and calibration transactions give no result.
// Synchronous active-low reset restores state, loop, limits and configuration.
// The result register lets a new transaction in while a result waits; a
// stalled output holds the sequencer at its result states.
module line_follow_pid_steering_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lfps_item_if.sink                           i_item,
    lfps_result_if.source                       o_result,
    input  logic                                i_cfg_we,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lfps_pkg::CFG_W-1:0]          i_cfg_data
);
    import lfps_pkg::*;

    t_cfg r_cfg;

    // Configuration registers, written one at a time by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain         <= KP_W'(333);
            r_cfg.kd_gain         <= KD_W'(2560);
            r_cfg.cruise_spd      <= SPD_W'(70);
            r_cfg.min_curve_speed <= SPD_W'(25);
            r_cfg.top_spd         <= SPD_W'(140);
            r_cfg.bridge_spd      <= SPD_W'(40);
            r_cfg.return_spd      <= SPD_W'(70);
            r_cfg.bridge_limit    <= GAPT_W'(150);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KP:   r_cfg.kp_gain         <= i_cfg_data[KP_W-1:0];
                CFG_KD:   r_cfg.kd_gain         <= i_cfg_data[KD_W-1:0];
                CFG_BASE: r_cfg.cruise_spd      <= i_cfg_data[SPD_W-1:0];
                CFG_MINC: r_cfg.min_curve_speed <= i_cfg_data[SPD_W-1:0];
                CFG_MAX:  r_cfg.top_spd         <= i_cfg_data[SPD_W-1:0];
                CFG_GAP:  r_cfg.bridge_spd      <= i_cfg_data[SPD_W-1:0];
                CFG_REC:  r_cfg.return_spd      <= i_cfg_data[SPD_W-1:0];
                CFG_GAPT: r_cfg.bridge_limit    <= i_cfg_data[GAPT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Gather the samples so that the lanes can be generated.
    logic [NUM_SENSORS-1:0][SAMPLE_BITS-1:0] samples;
    assign samples[0] = i_item.sample_ch0;
    assign samples[1] = i_item.sample_ch1;
    assign samples[2] = i_item.sample_ch2;
    assign samples[3] = i_item.sample_ch3;
    assign samples[4] = i_item.sample_ch4;
    assign samples[5] = i_item.sample_ch5;
    assign samples[6] = i_item.sample_ch6;
    assign samples[7] = i_item.sample_ch7;

    t_lane_cmd                          lane_cmd;
    logic [NUM_SENSORS-1:0][NORM_W-1:0] lane_norm;
    logic [NUM_SENSORS-1:0]             lane_busy;
    t_result                            res;
    logic                               in_ready;

    // Each lane holds its own calibration limits and normalises its channel.
    for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
        lfps_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (lane_cmd),
            .i_sample (samples[g]),
            .o_norm   (lane_norm[g]),
            .o_busy   (lane_busy[g])
        );
    end

    // The sequencer merges the lanes and runs the steering law.
    lfps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_item.valid),
        .i_req       (i_item.req_type),
        .o_in_ready  (in_ready),
        .i_norm      (lane_norm),
        .i_busy      (lane_busy),
        .o_cmd       (lane_cmd),
        .o_res_valid (o_result.valid),
        .i_res_ready (o_result.ready),
        .o_res       (res)
    );

    assign i_item.ready           = in_ready;
    assign o_result.left_forward  = res.left_forward;
    assign o_result.left_duty     = res.left_duty;
    assign o_result.right_forward = res.right_forward;
    assign o_result.right_duty    = res.right_duty;
    assign o_result.line_seen     = res.line_seen;
    assign o_result.run_ended     = res.run_ended;
    assign o_result.last_of_run   = res.last_of_run;

endmodule

// ===== tb/tb_line_follow_pid_steering_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for line_follow_pid_steering_top: a directed opening, then random
// phases under several register settings. Depends on lfps_pkg, lfps_if and the top level.
module tb_line_follow_pid_steering_top;
    import lfps_pkg::*;

    // Request code that the block must ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    // Settling time after the last result, above the longest control step.
    localparam int SETTLE_CYCLES = 200;

    typedef struct {
        logic [1:0] req;
        logic [9:0] ch [NUM_SENSORS];
    } t_sensor_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    lfps_item_if item_if ();
    lfps_result_if res_if ();

    line_follow_pid_steering_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Register copies held by the predictor.
    int kp_q, kd_q, base_q, minc_q, maxs_q, gaps_q, recs_q, gapt_q;
    // Loop state held by the predictor.
    int cal_lo [NUM_SENSORS];
    int cal_hi [NUM_SENSORS];
    longint err_prev, dfilt;
    int lost_cnt;
    bit run_over;

    t_sensor_item pending_items [$];
    t_result motor_expect_q [$];
    t_sensor_item on_bus;
    int errors = 0;
    longint cycles = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint round_near(longint n, longint d);
        longint mag, q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic void set_motor(int v, output logic fwd, output logic [7:0] duty);
        int m;
        m = (v < 0) ? -v : v;
        if (m > maxs_q) m = maxs_q;
        fwd = (v >= 0);
        duty = fwd ? 8'(255 - m) : 8'(m);
    endfunction

    function automatic t_result motor_pair(int l, int r, bit seen, bit last);
        t_result res;
        set_motor(l, res.left_forward, res.left_duty);
        set_motor(r, res.right_forward, res.right_duty);
        res.line_seen = seen;
        res.run_ended = run_over;
        res.last_of_run = last;
        return res;
    endfunction

    function automatic void clear_loop();
        for (int i = 0; i < NUM_SENSORS; i++) begin
            cal_lo[i] = 1023;
            cal_hi[i] = 0;
        end
        err_prev = 0;
        dfilt = 0;
        lost_cnt = 0;
        run_over = 0;
    endfunction

    // Works out the motor results that one accepted transaction causes.
    function automatic void steer_predict(t_sensor_item it);
        longint sw, sv, raw, lo, range, norm, e, ae, scale, drop, acc, adj, sp, d12;
        sw = 0;
        sv = 0;
        if (it.req == REQ_CLEAR) begin
            clear_loop();
            return;
        end
        if (it.req == REQ_CAL) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                if (it.ch[i] < cal_lo[i]) cal_lo[i] = it.ch[i];
                if (it.ch[i] > cal_hi[i]) cal_hi[i] = it.ch[i];
            end
            return;
        end
        if (it.req != REQ_STEP) return;
        if (run_over) begin
            motor_expect_q.push_back(motor_pair(0, 0, 0, 1));
            return;
        end
        for (int i = 0; i < NUM_SENSORS; i++) begin
            raw = it.ch[i];
            lo = cal_lo[i];
            range = longint'(cal_hi[i]) - lo;
            if (range >= MIN_RANGE) begin
                norm = (raw > lo) ? ((raw - lo) * NORM_FULL) / range : 0;
                if (norm > NORM_FULL) norm = NORM_FULL;
                if (norm > COUNT_FLOOR) begin
                    sw += norm * (20 * i - 10 * (NUM_SENSORS - 1));
                    sv += norm;
                end
            end
        end
        if (sv > SEEN_LEVEL) begin
            e = round_near(sw * 256, sv);
            ae = (e < 0) ? -e : e;
            scale = 256;
            drop = 307;
            lost_cnt = 0;
            // The deadband zeroes the error but the bands below still use its magnitude.
            if (ae < DEADBAND) e = 0;
            d12 = (e - err_prev) * 16;
            dfilt = round_near(dfilt * 3686 + d12 * 410, 4096);
            if (ae < LOW_BAND) scale = 77;
            else if (ae > HIGH_BAND) begin
                scale = 461;
                drop = 461;
            end
            acc = e * kp_q * scale + dfilt * kd_q * 16;
            adj = acc / (longint'(1) << 24);
            if (adj > ADJ_LIMIT) adj = ADJ_LIMIT;
            if (adj < -ADJ_LIMIT) adj = -ADJ_LIMIT;
            sp = longint'(base_q) - ((ae * drop) >>> 16);
            if (sp < minc_q) sp = minc_q;
            motor_expect_q.push_back(motor_pair(int'(sp - adj), int'(sp + adj), 1, 1));
            err_prev = e;
            return;
        end
        // The line is missing: a reverse kick on the first lost step only.
        if (lost_cnt == 0)
            motor_expect_q.push_back(motor_pair(-KICK_SPEED, -KICK_SPEED, 0, 0));
        if (lost_cnt < LOST_MAX) lost_cnt++;
        if (lost_cnt > LOST_LIMIT) begin
            run_over = 1;
            motor_expect_q.push_back(motor_pair(0, 0, 0, 1));
        end else if (lost_cnt < gapt_q && err_prev < GAP_BAND && err_prev > -GAP_BAND)
            motor_expect_q.push_back(motor_pair(gaps_q, gaps_q, 0, 1));
        else if (err_prev < -TURN_BAND)
            motor_expect_q.push_back(motor_pair(recs_q, -INNER_REVERSE, 0, 1));
        else if (err_prev > TURN_BAND)
            motor_expect_q.push_back(motor_pair(-INNER_REVERSE, recs_q, 0, 1));
        else
            motor_expect_q.push_back(motor_pair(gaps_q, gaps_q, 0, 1));
    endfunction

    // Item builders for the stimulus.
    function automatic t_sensor_item flat_item(logic [1:0] req, int val);
        t_sensor_item it;
        it.req = req;
        foreach (it.ch[i]) it.ch[i] = 10'(val);
        return it;
    endfunction

    function automatic t_sensor_item noise_item(logic [1:0] req);
        t_sensor_item it;
        it.req = req;
        foreach (it.ch[i]) it.ch[i] = 10'($urandom_range(0, 1023));
        return it;
    endfunction

    // A line under position pos, where 0 is the leftmost sensor and 70 the rightmost.
    function automatic t_sensor_item line_item(int pos);
        t_sensor_item it;
        int offset;
        it.req = REQ_STEP;
        foreach (it.ch[i]) begin
            offset = (i * 10 > pos) ? i * 10 - pos : pos - i * 10;
            if (offset < 12) it.ch[i] = 10'(1023 - offset * 30 - $urandom_range(0, 60));
            else it.ch[i] = 10'($urandom_range(0, 160));
        end
        return it;
    endfunction

    function automatic t_sensor_item lost_item();
        t_sensor_item it;
        it.req = REQ_STEP;
        foreach (it.ch[i]) it.ch[i] = 10'($urandom_range(0, 140));
        return it;
    endfunction

    // Calibration sweep: dark and bright samples, now and then a narrow channel.
    task automatic push_calibration();
        t_sensor_item it;
        int n;
        n = $urandom_range(2, 5);
        for (int k = 0; k < n; k++) begin
            it.req = REQ_CAL;
            foreach (it.ch[i]) begin
                if ($urandom_range(0, 15) == 0) it.ch[i] = 10'($urandom_range(480, 540));
                else if (k % 2 == 0) it.ch[i] = 10'($urandom_range(0, 130));
                else it.ch[i] = 10'($urandom_range(880, 1023));
            end
            pending_items.push_back(it);
        end
    endtask

    task automatic push_random_phase(int n_items, bit long_loss);
        int pick, run;
        pending_items.push_back(flat_item(REQ_CLEAR, 0));
        push_calibration();
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) pending_items.push_back(line_item($urandom_range(0, 70)));
            else if (pick < 80) begin
                // Lose the line after a far-off position so recovery turns are reached.
                pending_items.push_back(line_item($urandom_range(0, 1) ? 0 : 70));
                run = $urandom_range(1, 25);
                for (int j = 0; j < run; j++) pending_items.push_back(lost_item());
            end else if (pick < 86) push_calibration();
            else if (pick < 93) pending_items.push_back(noise_item(REQ_STEP));
            else if (pick < 96) pending_items.push_back(noise_item(REQ_UNUSED));
            else if (pick < 98) pending_items.push_back(noise_item(REQ_CAL));
            else begin
                pending_items.push_back(noise_item(REQ_CLEAR));
                push_calibration();
            end
        end
        if (long_loss) begin
            // Run past the lost limit, calibrate and step while ended, then clear.
            pending_items.push_back(line_item(5));
            for (int j = 0; j < LOST_LIMIT + 8; j++) pending_items.push_back(lost_item());
            pending_items.push_back(noise_item(REQ_CAL));
            pending_items.push_back(line_item(35));
            pending_items.push_back(line_item(35));
            pending_items.push_back(flat_item(REQ_CLEAR, 0));
            push_calibration();
            pending_items.push_back(line_item(40));
        end
    endtask

    task automatic cfg_write(t_cfg_idx idx, int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(val);
        case (idx)
            CFG_KP:   kp_q = val & 12'hFFF;
            CFG_KD:   kd_q = val & 13'h1FFF;
            CFG_BASE: base_q = val & 8'hFF;
            CFG_MINC: minc_q = val & 8'hFF;
            CFG_MAX:  maxs_q = val & 8'hFF;
            CFG_GAP:  gaps_q = val & 8'hFF;
            CFG_REC:  recs_q = val & 8'hFF;
            CFG_GAPT: gapt_q = val & 10'h3FF;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(int kp, int kd, int bs, int mc, int ms, int gs, int rs, int gt);
        cfg_write(CFG_KP, kp);
        cfg_write(CFG_KD, kd);
        cfg_write(CFG_BASE, bs);
        cfg_write(CFG_MINC, mc);
        cfg_write(CFG_MAX, ms);
        cfg_write(CFG_GAP, gs);
        cfg_write(CFG_REC, rs);
        cfg_write(CFG_GAPT, gt);
    endtask

    // Blocks until every queued transaction has gone in and every result has come out,
    // then lets the block settle, since clear and calibration leave nothing to wait on.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || item_if.valid);
        do @(posedge i_clk);
        while (motor_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: bursts of random length separated by random gaps. The prediction is made
    // on the edge at which the transaction is accepted, from the copy held on the bus.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) steer_predict(on_bus);
            if (!item_if.valid || item_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    item_if.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    on_bus = pending_items.pop_front();
                    item_if.valid <= 1'b1;
                    item_if.req_type <= on_bus.req;
                    item_if.sample_ch0 <= on_bus.ch[0];
                    item_if.sample_ch1 <= on_bus.ch[1];
                    item_if.sample_ch2 <= on_bus.ch[2];
                    item_if.sample_ch3 <= on_bus.ch[3];
                    item_if.sample_ch4 <= on_bus.ch[4];
                    item_if.sample_ch5 <= on_bus.ch[5];
                    item_if.sample_ch6 <= on_bus.ch[6];
                    item_if.sample_ch7 <= on_bus.ch[7];
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 30);
                        // A third of the gaps are empty, so bursts also run back to back.
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
                    end
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: the receiver alternates between free-running stretches and stalling
    // stretches, and every accepted transaction is checked against the oldest prediction.
    int stall_mode = 0;
    int mode_left = 0;
    t_result want;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(5, 300);
        end else mode_left--;
        case (stall_mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 3) != 0);
            default: res_if.ready <= ($urandom_range(0, 4) == 0);
        endcase
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (motor_expect_q.size() == 0) begin
                report_mismatch("predictions waiting", 0, 1);
            end else begin
                want = motor_expect_q.pop_front();
                if (res_if.left_forward !== want.left_forward)
                    report_mismatch("left_forward", res_if.left_forward, want.left_forward);
                if (res_if.left_duty !== want.left_duty)
                    report_mismatch("left_duty", res_if.left_duty, want.left_duty);
                if (res_if.right_forward !== want.right_forward)
                    report_mismatch("right_forward", res_if.right_forward, want.right_forward);
                if (res_if.right_duty !== want.right_duty)
                    report_mismatch("right_duty", res_if.right_duty, want.right_duty);
                if (res_if.line_seen !== want.line_seen)
                    report_mismatch("line_seen", res_if.line_seen, want.line_seen);
                if (res_if.run_ended !== want.run_ended)
                    report_mismatch("run_ended", res_if.run_ended, want.run_ended);
                if (res_if.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", res_if.last_of_run, want.last_of_run);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("line_follow_pid_steering_top regression: fail");
            $finish;
        end
    end

    initial begin
        item_if.valid = 1'b0;
        item_if.req_type = REQ_CLEAR;
        item_if.sample_ch0 = '0;
        item_if.sample_ch1 = '0;
        item_if.sample_ch2 = '0;
        item_if.sample_ch3 = '0;
        item_if.sample_ch4 = '0;
        item_if.sample_ch5 = '0;
        item_if.sample_ch6 = '0;
        item_if.sample_ch7 = '0;
        res_if.ready = 1'b0;
        kp_q = 333;
        kd_q = 2560;
        base_q = 70;
        minc_q = 25;
        maxs_q = 140;
        gaps_q = 40;
        recs_q = 70;
        gapt_q = 150;
        clear_loop();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening under the reset settings. The first step finds no calibrated
        // channel, so it is lost and kicks in reverse.
        pending_items.push_back(flat_item(REQ_STEP, 1023));
        pending_items.push_back(flat_item(REQ_CAL, 0));
        pending_items.push_back(flat_item(REQ_CAL, 1023));
        pending_items.push_back(flat_item(REQ_STEP, 1023));
        pending_items.push_back(flat_item(REQ_STEP, 0));
        pending_items.push_back(flat_item(REQ_STEP, 0));
        pending_items.push_back(line_item(35));
        pending_items.push_back(line_item(0));
        pending_items.push_back(line_item(70));
        pending_items.push_back(line_item(15));
        pending_items.push_back(flat_item(REQ_STEP, 0));
        pending_items.push_back(line_item(60));
        pending_items.push_back(flat_item(REQ_STEP, 0));
        pending_items.push_back(flat_item(REQ_UNUSED, 1023));
        pending_items.push_back(line_item(33));
        pending_items.push_back(flat_item(REQ_CLEAR, 1023));
        // Narrow channels only: every channel is skipped and the line is never found.
        pending_items.push_back(flat_item(REQ_CAL, 500));
        pending_items.push_back(flat_item(REQ_CAL, 560));
        pending_items.push_back(line_item(35));
        pending_items.push_back(flat_item(REQ_STEP, 1023));
        wait_idle();

        cfg_all(4095, 8191, 255, 255, 255, 255, 255, 1023);
        push_random_phase(80, 0);
        wait_idle();

        cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
        push_random_phase(60, 0);
        wait_idle();

        cfg_all(333, 2560, 70, 25, 140, 40, 70, 150);
        push_random_phase(80, 1);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            cfg_all($urandom_range(0, 4095), $urandom_range(0, 8191), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 40));
            push_random_phase(50, 0);
            wait_idle();
        end

        if (errors == 0) $display("line_follow_pid_steering_top regression: pass");
        else $display("line_follow_pid_steering_top regression: fail");
        $finish;
    end

endmodule
